/* hdl/latency_histogram_census_macros.svh */
// assertion macros shared by the census rtl
`ifndef LATENCY_HISTOGRAM_CENSUS_MACROS_SVH
`define LATENCY_HISTOGRAM_CENSUS_MACROS_SVH

// same-cycle implication
`define LHC_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LHC_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lhc_pkg.sv */
package lhc_pkg;
	localparam int BUCKET_COUNT_DEF = 1001;
	localparam int SERIES_NUM = 4;
	localparam int SERIES_W = 2;
	localparam logic [16:0] BUCKET_NS = 17'd100000;
	localparam logic [19:0] NS_PER_MS = 20'd1000000;
	localparam logic [13:0] BP_FULL = 14'd10000;
	// ceil(2^36 / 3125): (ns >> 5) * BKT_RCP >> 36 is ns / 100000 for ns below 2^29
	localparam logic [24:0] BKT_RCP = 25'd21990233;
	localparam int BKT_RCP_SH = 36;

	typedef enum logic [2:0] {
		OP_QUEUE   = 3'd0,
		OP_CAPTURE = 3'd1,
		OP_COMMIT  = 3'd2,
		OP_PRESENT = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;
endpackage

/* hdl/lhc_if.sv */
interface lhc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [63:0] timestamp_ns;
	logic [31:0] residency_ms;
	logic [1:0]  series_select;
	logic [13:0] percentile_bp;
	modport source(output valid, opcode, timestamp_ns, residency_ms, series_select,
		percentile_bp, input ready);
	modport sink(input valid, opcode, timestamp_ns, residency_ms, series_select,
		percentile_bp, output ready);
endinterface

interface lhc_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] percentile_ns;
	logic [31:0] sample_count;
	logic [63:0] total_latency_ns;
	logic [63:0] max_latency_ns;
	logic [31:0] uncaptured_count;
	modport source(output valid, percentile_ns, sample_count, total_latency_ns,
		max_latency_ns, uncaptured_count, input ready);
	modport sink(input valid, percentile_ns, sample_count, total_latency_ns,
		max_latency_ns, uncaptured_count, output ready);
endinterface

/* hdl/lhc_ram.sv */
module lhc_ram #(
	parameter int W = 32,
	parameter int D = 4096
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hdl/latency_histogram_census.sv */
// handshake: an event keeps req.ready low until it is done (dispatch, then bucket index, ram read
// and ram write per sample; a commit can add two samples), so a new event waits for the last one
// a query walks the buckets from the lowest, a ram read and an accumulate per bucket, until the
// threshold is passed or the last bucket; its result waits while an earlier one is held on rsp
// one transaction at a time; reset: arst_n asynchronous active low, then a clearing pass over all
// 4<<clog2(BUCKET_COUNT) ram entries (4096 at the default) zeroes the bucket ram before any accept
module latency_histogram_census #(
	parameter int BUCKET_COUNT = lhc_pkg::BUCKET_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	lhc_req_if.sink   req,
	lhc_rsp_if.source rsp
);
	import lhc_pkg::*;
	`include "latency_histogram_census_macros.svh"

	localparam int IW = $clog2(BUCKET_COUNT);
	localparam int AW = SERIES_W + IW;
	localparam int DEPTH = SERIES_NUM << IW;
	localparam int ACC_W = 32 + IW + 15;
	localparam logic [IW-1:0] LAST_IDX = IW'(BUCKET_COUNT - 1);
	localparam logic [63:0] LIMIT_NS = 64'(BUCKET_COUNT - 1) * 64'(BUCKET_NS);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DISP, ST_TICK, ST_CFIN, ST_AS_LIM, ST_AS_RD,
		ST_AS_WR, ST_Q_MUL, ST_Q_RD, ST_Q_ACC, ST_Q_EDGE, ST_Q_OUT
	} state_t;

	state_t state_q, ret_q;
	logic              en_q;
	logic [AW-1:0]     clr_q;
	logic [2:0]        op_q;
	logic [63:0]       t_q;
	logic [31:0]       qms_q;
	logic [1:0]        sel_q;
	logic [13:0]       bp_q;
	logic [31:0]       cnt_q [SERIES_NUM];
	logic [63:0]       tot_q [SERIES_NUM];
	logic [63:0]       max_q [SERIES_NUM];
	logic [63:0]       lcap_q, lcom_q;
	logic              csc_q, pend_q;
	logic [31:0]       unc_q;
	logic [63:0]       smp_ns_q;
	logic [1:0]        smp_s_q;
	logic [IW-1:0]     idx_q;
	logic [45:0]       thr_q;
	logic [ACC_W-1:0]  acc_q;
	logic [63:0]       pct_q;
	logic              rsp_valid_q;
	logic [63:0]       o_pct_q, o_tot_q, o_max_q;
	logic [31:0]       o_cnt_q, o_unc_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [31:0]       ram_wdata, ram_rdata;
	logic [51:0]       qprod;
	logic [45:0]       bprod;
	logic [48:0]       bkt_prod;
	logic [45:0]       bscl;
	logic [ACC_W-1:0]  acc_sum;
	logic [64:0]       tot_sum;
	logic [IW:0]       nidx;

	assign qprod = 52'(qms_q) * 52'(NS_PER_MS);
	assign bprod = 46'(cnt_q[sel_q]) * 46'(bp_q);
	assign bkt_prod = 49'(smp_ns_q[28:5]) * 49'(BKT_RCP);
	// seen >= max(1, count*bp/10000) is the same as seen*10000 > thr_q
	assign bscl = 46'(ram_rdata) * 46'(BP_FULL);
	assign acc_sum = acc_q + ACC_W'(bscl);
	assign tot_sum = {1'b0, tot_q[smp_s_q]} + {1'b0, smp_ns_q};
	assign nidx = {1'b0, idx_q} + 1'b1;

	assign ram_we = (state_q == ST_CLEAR) || (state_q == ST_AS_WR);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : {smp_s_q, idx_q};
	assign ram_wdata = (state_q == ST_CLEAR) ? 32'd0 :
		((ram_rdata == 32'hFFFF_FFFF) ? ram_rdata : ram_rdata + 32'd1);
	assign ram_raddr = (state_q == ST_Q_RD) ? {sel_q, idx_q} : {smp_s_q, idx_q};

	lhc_ram #(.W(32), .D(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.percentile_ns = o_pct_q;
	assign rsp.sample_count = o_cnt_q;
	assign rsp.total_latency_ns = o_tot_q;
	assign rsp.max_latency_ns = o_max_q;
	assign rsp.uncaptured_count = o_unc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q <= ST_IDLE;
			en_q <= 1'b0;
			clr_q <= '0;
			for (int s = 0; s < SERIES_NUM; s++) begin
				cnt_q[s] <= '0;
				tot_q[s] <= '0;
				max_q[s] <= '0;
			end
			lcap_q <= '0;
			lcom_q <= '0;
			csc_q <= 1'b0;
			pend_q <= 1'b0;
			unc_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				en_q <= cfg_data;
			end
			if (rsp_valid_q && rsp.ready && state_q != ST_Q_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						op_q <= req.opcode;
						t_q <= req.timestamp_ns;
						qms_q <= req.residency_ms;
						sel_q <= req.series_select;
						bp_q <= req.percentile_bp;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (op_q == OP_QUERY) begin
						if (cnt_q[sel_q] == '0) begin
							pct_q <= '0;
							state_q <= ST_Q_OUT;
						end else begin
							state_q <= ST_Q_MUL;
						end
					end else if (!en_q) begin
						state_q <= ST_IDLE;
					end else begin
						case (op_q)
							OP_QUEUE: begin
								smp_ns_q <= 64'(qprod);
								smp_s_q <= 2'd0;
								ret_q <= ST_IDLE;
								state_q <= ST_AS_LIM;
							end
							OP_CAPTURE: begin
								lcap_q <= t_q;
								csc_q <= 1'b1;
								state_q <= ST_IDLE;
							end
							OP_COMMIT: begin
								if (csc_q && t_q >= lcap_q) begin
									smp_ns_q <= t_q - lcap_q;
									smp_s_q <= 2'd1;
									ret_q <= ST_TICK;
									state_q <= ST_AS_LIM;
								end else begin
									if (!csc_q && unc_q != 32'hFFFF_FFFF) begin
										unc_q <= unc_q + 32'd1;
									end
									state_q <= ST_TICK;
								end
							end
							OP_PRESENT: begin
								if (pend_q && lcom_q != '0 && t_q >= lcom_q) begin
									smp_ns_q <= t_q - lcom_q;
									smp_s_q <= 2'd3;
									pend_q <= 1'b0;
									ret_q <= ST_IDLE;
									state_q <= ST_AS_LIM;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_TICK: begin
					if (lcom_q != '0 && t_q >= lcom_q) begin
						smp_ns_q <= t_q - lcom_q;
						smp_s_q <= 2'd2;
						ret_q <= ST_CFIN;
						state_q <= ST_AS_LIM;
					end else begin
						state_q <= ST_CFIN;
					end
				end
				ST_CFIN: begin
					lcom_q <= t_q;
					csc_q <= 1'b0;
					pend_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_AS_LIM: begin
					if (smp_ns_q >= LIMIT_NS) begin
						idx_q <= LAST_IDX;
					end else begin
						idx_q <= bkt_prod[BKT_RCP_SH +: IW];
					end
					state_q <= ST_AS_RD;
				end
				ST_AS_RD: state_q <= ST_AS_WR;
				ST_AS_WR: begin
					if (cnt_q[smp_s_q] != 32'hFFFF_FFFF) begin
						cnt_q[smp_s_q] <= cnt_q[smp_s_q] + 32'd1;
					end
					tot_q[smp_s_q] <= tot_sum[64] ? '1 : tot_sum[63:0];
					if (smp_ns_q > max_q[smp_s_q]) begin
						max_q[smp_s_q] <= smp_ns_q;
					end
					state_q <= ret_q;
				end
				ST_Q_MUL: begin
					thr_q <= (bprod >= 46'(BP_FULL)) ? bprod - 46'(BP_FULL) : '0;
					acc_q <= '0;
					idx_q <= '0;
					state_q <= ST_Q_RD;
				end
				ST_Q_RD: state_q <= ST_Q_ACC;
				ST_Q_ACC: begin
					acc_q <= acc_sum;
					if (idx_q == LAST_IDX) begin
						pct_q <= max_q[sel_q];
						state_q <= ST_Q_OUT;
					end else if (acc_sum > ACC_W'(thr_q)) begin
						state_q <= ST_Q_EDGE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_Q_RD;
					end
				end
				ST_Q_EDGE: begin
					pct_q <= 64'(29'(nidx) * 29'(BUCKET_NS));
					state_q <= ST_Q_OUT;
				end
				ST_Q_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						o_pct_q <= pct_q;
						o_cnt_q <= cnt_q[sel_q];
						o_tot_q <= tot_q[sel_q];
						o_max_q <= max_q[sel_q];
						o_unc_q <= unc_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LHC_IMPLY(a_clear_busy, state_q == ST_CLEAR, !req.ready, "accepting during clear pass")
	`LHC_IMPLY(a_we_legal, ram_we, state_q == ST_CLEAR || state_q == ST_AS_WR, "stray ram write")
	`LHC_NEXT(a_accept_disp, req.valid && req.ready, state_q == ST_DISP, "accept lost")
	`LHC_IMPLY(a_walk_bound, state_q == ST_Q_ACC, idx_q <= LAST_IDX, "walk past last bucket")
endmodule
